/* rtl/rpn_stack_evaluator_macros.svh */
// Assertion macros used by the RPN evaluator RTL.
`ifndef RPN_STACK_EVALUATOR_MACROS_SVH
`define RPN_STACK_EVALUATOR_MACROS_SVH
`ifndef SYNTHESIS
// Property that must hold at every clock edge out of reset.
`define RPN_ASSERT_ALW(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("rpn: assertion failed");
// Implication checked at every clock edge out of reset.
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rpn: assertion failed");
`else
`define RPN_ASSERT_ALW(label, clk, rst_n, prop)
`define RPN_ASSERT_IMP(label, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/rpn_pkg.sv */
// Package: character codes, status codes and defaults of the RPN evaluator.
`default_nettype none
package rpn_pkg;

    typedef logic [1:0] status_t;
    typedef logic [7:0] char_t;

    localparam int STACK_DEPTH_DEF = 128;
    localparam int DATA_W          = 32;

    localparam char_t SYM_EQ    = 8'h3D; // '='
    localparam char_t SYM_ZERO  = 8'h30; // '0'
    localparam char_t SYM_NINE  = 8'h39; // '9'
    localparam char_t SYM_PLUS  = 8'h2B; // '+'
    localparam char_t SYM_MINUS = 8'h2D; // '-'
    localparam char_t SYM_MUL   = 8'h2A; // '*'
    localparam char_t SYM_DIV   = 8'h2F; // '/'

    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_UNDER   = 2'd1;
    localparam status_t ST_FULL    = 2'd2;
    localparam status_t ST_DIVZERO = 2'd3;

endpackage
`default_nettype wire

/* rtl/rpn_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module rpn_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

/* rtl/rpn_stack_evaluator.sv */
// Reverse Polish expression evaluator over a stack of signed 32-bit values.
//
// Input channel (in_valid/in_ready/symbol): one ASCII character per beat.
// Digits push, + - * / pop two and push b op a, '=' pops the result and
// clears the stack; other characters are dropped.
// Output channel (out_valid/out_ready/result_value/status): one beat per
// '=' and one per error (underflow, stack full, divide by zero); errors
// clear the stack and carry a zero value.
// in_ready is high only when the sequencer is idle. Digits and ignored
// characters finish in S_IDLE; + - * pass S_RDA, S_RDB; '/' adds S_DIV
// (one quotient bit per cycle), S_DIVEND; '=' S_EQ, S_EMIT; errors end in
// S_EMIT. Stack reads use the single registered RAM read port, one per cycle.
// A result sits in an output register; the next character is accepted
// while it waits. A new result waits in the sequencer until the output
// register is taken, so a stalled receiver stalls the input only then.
// Reset empties the stack (depth count to zero) and drops any pending beat;
// stack contents need no clearing.
`default_nettype none
`include "rpn_stack_evaluator_macros.svh"
module rpn_stack_evaluator #(
    parameter int STACK_DEPTH = rpn_pkg::STACK_DEPTH_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire rpn_pkg::char_t        symbol,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic signed [31:0]         result_value,
    output rpn_pkg::status_t           status
);

    import rpn_pkg::*;

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DW = $clog2(STACK_DEPTH + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EQ     = 3'd1;
    localparam logic [2:0] S_RDA    = 3'd2;
    localparam logic [2:0] S_RDB    = 3'd3;
    localparam logic [2:0] S_DIV    = 3'd4;
    localparam logic [2:0] S_DIVEND = 3'd5;
    localparam logic [2:0] S_EMIT   = 3'd6;

    localparam logic [1:0] OP_ADD = 2'd0;
    localparam logic [1:0] OP_SUB = 2'd1;
    localparam logic [1:0] OP_MUL = 2'd2;
    localparam logic [1:0] OP_DIV = 2'd3;

    logic [2:0]        state_reg, state_next;
    logic [DW-1:0]     depth_reg, depth_next;
    logic [1:0]        op_reg, op_next;
    logic [DATA_W-1:0] a_reg, a_next;
    logic [DATA_W-1:0] rem_reg, rem_next;
    logic [DATA_W-1:0] quo_reg, quo_next;
    logic [DATA_W-1:0] divisor_reg, divisor_next;
    logic              neg_reg, neg_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [DATA_W-1:0] res_value_reg, res_value_next;
    status_t           res_status_reg, res_status_next;
    logic              out_valid_reg, out_valid_next;
    logic [DATA_W-1:0] result_value_reg, result_value_next;
    status_t           status_reg, status_next;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    logic [DATA_W-1:0] ram_wdata;
    logic [AW-1:0]     ram_raddr;
    logic [DATA_W-1:0] ram_rdata;

    logic [DW-1:0]     depth_m1;
    logic [DW-1:0]     depth_m2;
    logic              is_digit;
    logic              is_op;
    logic [1:0]        op_code;
    logic [DATA_W-1:0] mul_lo;
    logic [DATA_W:0]   div_shift;
    logic [DATA_W:0]   div_diff;
    logic              div_ge;

    assign depth_m1 = depth_reg - DW'(1);
    assign depth_m2 = depth_reg - DW'(2);
    assign is_digit = (symbol >= SYM_ZERO) && (symbol <= SYM_NINE);
    assign is_op    = (symbol == SYM_PLUS) || (symbol == SYM_MINUS) ||
                      (symbol == SYM_MUL)  || (symbol == SYM_DIV);

    always_comb
    begin
        case (symbol)
            SYM_PLUS:  op_code = OP_ADD;
            SYM_MINUS: op_code = OP_SUB;
            SYM_MUL:   op_code = OP_MUL;
            default:   op_code = OP_DIV;
        endcase
    end

    // ram_rdata holds operand b while in S_RDB
    assign mul_lo = DATA_W'(ram_rdata * a_reg);

    // restoring divide step; remainder stays below divisor
    assign div_shift = {rem_reg, quo_reg[DATA_W-1]};
    assign div_diff  = div_shift - {1'b0, divisor_reg};
    assign div_ge    = div_shift >= {1'b0, divisor_reg};

    always_comb
    begin
        state_next      = state_reg;
        depth_next      = depth_reg;
        op_next         = op_reg;
        a_next          = a_reg;
        rem_next        = rem_reg;
        quo_next        = quo_reg;
        divisor_next    = divisor_reg;
        neg_next        = neg_reg;
        cnt_next        = cnt_reg;
        res_value_next  = res_value_reg;
        res_status_next = res_status_reg;
        out_valid_next  = out_valid_reg & ~out_ready;
        result_value_next = result_value_reg;
        status_next     = status_reg;
        ram_we          = 1'b0;
        ram_waddr       = depth_m2[AW-1:0];
        ram_wdata       = '0;
        ram_raddr       = depth_m1[AW-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (symbol == SYM_EQ)
                    begin
                        if (depth_reg == '0)
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_UNDER;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            state_next = S_EQ;
                        end
                    end
                    else if (is_digit)
                    begin
                        if (depth_reg >= DW'(STACK_DEPTH))
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_FULL;
                            depth_next      = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            ram_we     = 1'b1;
                            ram_waddr  = depth_reg[AW-1:0];
                            ram_wdata  = DATA_W'(symbol - SYM_ZERO);
                            depth_next = depth_reg + DW'(1);
                        end
                    end
                    else if (is_op)
                    begin
                        if (depth_reg < DW'(2))
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_UNDER;
                            depth_next      = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            op_next    = op_code;
                            state_next = S_RDA;
                        end
                    end
                end
            end
            S_EQ:
            begin
                res_value_next  = ram_rdata;
                res_status_next = ST_OK;
                depth_next      = '0;
                state_next      = S_EMIT;
            end
            S_RDA:
            begin
                a_next     = ram_rdata;
                ram_raddr  = depth_m2[AW-1:0];
                state_next = S_RDB;
            end
            S_RDB:
            begin
                case (op_reg)
                    OP_ADD:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = ram_rdata + a_reg;
                        depth_next = depth_m1;
                        state_next = S_IDLE;
                    end
                    OP_SUB:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = ram_rdata - a_reg;
                        depth_next = depth_m1;
                        state_next = S_IDLE;
                    end
                    OP_MUL:
                    begin
                        ram_we     = 1'b1;
                        ram_wdata  = mul_lo;
                        depth_next = depth_m1;
                        state_next = S_IDLE;
                    end
                    default:
                    begin
                        if (a_reg == '0)
                        begin
                            res_value_next  = '0;
                            res_status_next = ST_DIVZERO;
                            depth_next      = '0;
                            state_next      = S_EMIT;
                        end
                        else
                        begin
                            quo_next     = ram_rdata[DATA_W-1] ? (DATA_W'(0) - ram_rdata)
                                                               : ram_rdata;
                            divisor_next = a_reg[DATA_W-1] ? (DATA_W'(0) - a_reg) : a_reg;
                            neg_next     = ram_rdata[DATA_W-1] ^ a_reg[DATA_W-1];
                            rem_next     = '0;
                            cnt_next     = '0;
                            state_next   = S_DIV;
                        end
                    end
                endcase
            end
            S_DIV:
            begin
                rem_next = div_ge ? div_diff[DATA_W-1:0] : div_shift[DATA_W-1:0];
                quo_next = {quo_reg[DATA_W-2:0], div_ge};
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'd31)
                begin
                    state_next = S_DIVEND;
                end
            end
            S_DIVEND:
            begin
                ram_we     = 1'b1;
                ram_wdata  = neg_reg ? (DATA_W'(0) - quo_reg) : quo_reg;
                depth_next = depth_m1;
                state_next = S_IDLE;
            end
            S_EMIT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    result_value_next = res_value_reg;
                    status_next       = res_status_reg;
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg           <= op_next;
        a_reg            <= a_next;
        rem_reg          <= rem_next;
        quo_reg          <= quo_next;
        divisor_reg      <= divisor_next;
        neg_reg          <= neg_next;
        res_value_reg    <= res_value_next;
        res_status_reg   <= res_status_next;
        result_value_reg <= result_value_next;
        status_reg       <= status_next;
    end

    rpn_ram #(
        .WIDTH (DATA_W),
        .DEPTH (STACK_DEPTH)
    ) u_stack (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready     = (state_reg == S_IDLE);
    assign out_valid    = out_valid_reg;
    assign result_value = signed'(result_value_reg);
    assign status       = status_reg;

    `RPN_ASSERT_ALW(a_depth_bound, clk, rst_n, depth_reg <= DW'(STACK_DEPTH))
    `RPN_ASSERT_IMP(a_err_zero, clk, rst_n, out_valid && status != ST_OK, result_value == 0)
    `RPN_ASSERT_IMP(a_div_nonzero, clk, rst_n, state_reg == S_DIV, divisor_reg != '0)
    `RPN_ASSERT_IMP(a_rem_below, clk, rst_n, state_reg == S_DIV, rem_reg < divisor_reg)
    `RPN_ASSERT_IMP(a_op_depth, clk, rst_n, state_reg == S_RDA, depth_reg >= DW'(2))

endmodule
`default_nettype wire

/* tb/tb.sv */
// Testbench for the RPN stack evaluator: answer scoreboard, beat drivers and checks.
`timescale 1ns / 100ps

module tb;
    import rpn_pkg::*;

    localparam int DEPTH      = STACK_DEPTH_DEF;
    localparam int LIVE_ITEMS = 1900;
    localparam int HOLD_OFF   = 300;

    typedef struct packed {
        logic [31:0] value;
        status_t     code;
    } answer_t;

    // Character class test shared by the drivers and the noise source.
    function automatic bit is_live(char_t ch);
        return ch == SYM_EQ || (ch >= SYM_ZERO && ch <= SYM_NINE) || ch == SYM_PLUS
            || ch == SYM_MINUS || ch == SYM_MUL || ch == SYM_DIV;
    endfunction

    class evaluator_scoreboard;
        logic [31:0] operands [DEPTH];
        int          depth;
        answer_t     pending_answers [$];
        int          mismatches;

        function void add_answer(logic [31:0] value, status_t code);
            answer_t ans;
            ans.value = value;
            ans.code  = code;
            pending_answers.push_back(ans);
        endfunction

        function void fail_clear(status_t code);
            depth = 0;
            add_answer(32'd0, code);
        endfunction

        // Predicts the effect of one accepted symbol.
        function void note_symbol(char_t ch);
            logic [31:0] a, b, r, ma, mb, q;
            if (depth > DEPTH)
                depth = 0;
            if (ch == SYM_EQ)
            begin
                if (depth == 0)
                begin
                    fail_clear(ST_UNDER);
                end
                else
                begin
                    r = operands[depth - 1];
                    depth = 0;
                    add_answer(r, ST_OK);
                end
            end
            else if (ch >= SYM_ZERO && ch <= SYM_NINE)
            begin
                if (depth >= DEPTH)
                begin
                    fail_clear(ST_FULL);
                end
                else
                begin
                    operands[depth] = 32'(ch - SYM_ZERO);
                    depth++;
                end
            end
            else if (ch == SYM_PLUS || ch == SYM_MINUS || ch == SYM_MUL || ch == SYM_DIV)
            begin
                if (depth < 2)
                begin
                    fail_clear(ST_UNDER);
                end
                else
                begin
                    a = operands[depth - 1];
                    b = operands[depth - 2];
                    depth -= 2;
                    if (ch == SYM_DIV && a == 32'd0)
                    begin
                        fail_clear(ST_DIVZERO);
                    end
                    else
                    begin
                        case (ch)
                            SYM_PLUS:  r = b + a;
                            SYM_MINUS: r = b - a;
                            SYM_MUL:   r = b * a;
                            default:
                            begin
                                // magnitudes keep most-negative / -1 from trapping
                                mb = b[31] ? -b : b;
                                ma = a[31] ? -a : a;
                                q  = mb / ma;
                                r  = (b[31] != a[31]) ? -q : q;
                            end
                        endcase
                        operands[depth] = r;
                        depth++;
                    end
                end
            end
        endfunction

        function void note_mismatch(string what, answer_t want, logic [31:0] value,
                                    status_t code);
            mismatches++;
            if (mismatches <= 10)
                $display("%0t mismatch (%s): expected %0d status %0d, got %0d status %0d",
                         $realtime, what, $signed(want.value), want.code, $signed(value), code);
        endfunction

        function void check_answer(logic [31:0] value, status_t code);
            answer_t want;
            if (pending_answers.size() == 0)
            begin
                want = '0;
                note_mismatch("no result expected", want, value, code);
                return;
            end
            want = pending_answers.pop_front();
            if (want.value !== value || want.code !== code)
                note_mismatch("field", want, value, code);
        endfunction
    endclass

    logic                clk = 1'b0;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    char_t               symbol;
    logic                out_valid;
    logic                out_ready;
    logic signed [31:0]  result_value;
    status_t             status;

    evaluator_scoreboard board = new;
    int                  live_sent;
    int                  tx_calm;
    int                  rx_calm;
    bit                  receiver_hold;
    char_t               op_set [4] = '{SYM_PLUS, SYM_MINUS, SYM_MUL, SYM_DIV};

    rpn_stack_evaluator #(.STACK_DEPTH(DEPTH)) DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .symbol       (symbol),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result_value (result_value),
        .status       (status)
    );

    always #5 clk = ~clk;

    // Idle cycles before a beat; now and then a calm stretch with none.
    function automatic int draw_wait(inout int calm);
        if (calm > 0)
        begin
            calm--;
            return 0;
        end
        if ($urandom_range(0, 19) == 0)
        begin
            calm = $urandom_range(10, 40);
            return 0;
        end
        return $urandom_range(0, 18);
    endfunction

    function automatic char_t ignored_char();
        char_t c;
        do
            c = char_t'($urandom_range(0, 255));
        while (is_live(c));
        return c;
    endfunction

    function automatic char_t rand_digit();
        return char_t'(SYM_ZERO + $urandom_range(0, 9));
    endfunction

    // Called and returns at a falling edge; valid stays up for a back-to-back beat.
    task automatic send_symbol(char_t ch);
        int gap;
        gap = draw_wait(tx_calm);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        symbol   <= ch;
        do
            @(posedge clk);
        while (in_ready !== 1'b1);
        board.note_symbol(ch);
        if (is_live(ch))
            live_sent++;
        @(negedge clk);
    endtask

    task automatic send_text(string s);
        for (int i = 0; i < s.len(); i++)
            send_symbol(char_t'(s[i]));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (board.pending_answers.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Well-formed expression; push_first builds a deep stack before reducing it.
    task automatic send_expression(int n_ops, bit push_first);
        int pushes_left, ops_left, depth_now;
        pushes_left = n_ops + 1 + (($urandom_range(0, 3) == 0) ? $urandom_range(1, 3) : 0);
        ops_left    = n_ops;
        depth_now   = 0;
        while (pushes_left > 0 || ops_left > 0)
        begin
            if ($urandom_range(0, 9) == 0)
                send_symbol(ignored_char());
            if (ops_left > 0 && depth_now >= 2
                && (pushes_left == 0 || (!push_first && $urandom_range(0, 1) == 1)))
            begin
                send_symbol(op_set[$urandom_range(0, 3)]);
                ops_left--;
                depth_now--;
            end
            else
            begin
                send_symbol(rand_digit());
                pushes_left--;
                depth_now++;
            end
        end
        send_symbol(SYM_EQ);
    endtask

    // 8^10 * 2 wraps to the most negative value, then a tail around it.
    task automatic send_min_chain();
        send_symbol(char_t'(SYM_ZERO + 8));
        repeat (9) send_text("8*");
        send_text("2*");
        case ($urandom_range(0, 3))
            0: send_text("01-/=");
            1: send_text("1-=");
            2: send_text("01-*=");
            default: send_text("=");
        endcase
    endtask

    task automatic fill_stack();
        repeat (DEPTH + 1) send_symbol(rand_digit());
        if ($urandom_range(0, 1) == 1)
            send_symbol(SYM_EQ);
    endtask

    task automatic send_broken();
        repeat ($urandom_range(1, 8))
        begin
            if ($urandom_range(0, 1) == 1)
                send_symbol(char_t'($urandom_range(0, 255)));
            else if ($urandom_range(0, 2) == 0)
                send_symbol(SYM_EQ);
            else if ($urandom_range(0, 1) == 1)
                send_symbol(op_set[$urandom_range(0, 3)]);
            else
                send_symbol(rand_digit());
        end
    endtask

    // Result side
    initial
    begin
        int stall;
        out_ready = 1'b0;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            if (receiver_hold)
            begin
                stall = HOLD_OFF;
                receiver_hold = 1'b0;
            end
            else
            begin
                stall = draw_wait(rx_calm);
            end
            if (stall > 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (out_valid !== 1'b1);
            board.check_answer(result_value, status);
            @(negedge clk);
        end
    end

    // Symbol side and end of run
    initial
    begin
        int pick;
        rst_n    = 1'b0;
        in_valid = 1'b0;
        symbol   = '0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;

        // equals on empty, operator short of operands, all ops, divide by zero,
        // extremes of the symbol byte
        send_text("=");
        send_text("7+");
        send_text("95-=");
        send_text("96*3/4+2-=");
        send_text("50/");
        send_symbol(8'h00);
        send_symbol(8'hFF);
        send_text("07-4/=");

        // receiver holds off while results pile up and the input stalls
        wait_drained();
        receiver_hold = 1'b1;
        send_text("1=2=3=4=5=6=7=8=");
        wait_drained();

        send_min_chain();
        fill_stack();

        while (live_sent < LIVE_ITEMS)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 66)
                send_expression($urandom_range(1, 12), 1'b0);
            else if (pick < 70)
                send_expression($urandom_range(20, DEPTH - 4), 1'b1);
            else if (pick < 72)
                fill_stack();
            else if (pick < 76)
                send_min_chain();
            else
                send_broken();
            if ($urandom_range(0, 49) == 0)
                wait_drained();
        end

        wait_drained();
        repeat (60) @(posedge clk);
        if (board.mismatches == 0 && board.pending_answers.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
